/* rtl/fcta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor cast texel address package
// Field widths, register indexes, reset values and screen size defaults.
// ----------------------------------------------------------------------------
package fcta_pkg;

  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned TEX_LOG_W = 4;
  localparam int unsigned TEXEL_W   = 8;
  localparam int unsigned WORLD_W   = 32;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned H_PIXELS_DEF = 640;
  localparam int unsigned V_PIXELS_DEF = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X      = 4'd0,
    CFG_POS_Y      = 4'd1,
    CFG_DIR_X      = 4'd2,
    CFG_DIR_Y      = 4'd3,
    CFG_PLANE_X    = 4'd4,
    CFG_PLANE_Y    = 4'd5,
    CFG_TEX_W_LOG2 = 4'd6,
    CFG_TEX_H_LOG2 = 4'd7
  } cfg_reg_e;

  localparam logic [COORD_W-1:0]          POS_X_RST      = 16'd384;
  localparam logic [COORD_W-1:0]          POS_Y_RST      = 16'd384;
  localparam logic signed [COORD_W-1:0]   DIR_X_RST      = 16'sd16384;
  localparam logic signed [COORD_W-1:0]   DIR_Y_RST      = 16'sd0;
  localparam logic signed [COORD_W-1:0]   PLANE_X_RST    = 16'sd0;
  localparam logic signed [COORD_W-1:0]   PLANE_Y_RST    = 16'sd10813;
  localparam logic [TEX_LOG_W-1:0]        TEX_W_LOG2_RST = 4'd6;
  localparam logic [TEX_LOG_W-1:0]        TEX_H_LOG2_RST = 4'd6;

endpackage

/* rtl/floor_cast_texel_address.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor cast texel address
// Maps a screen pixel below the horizon to the floor map cell and texel.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                   Transfer on
// in       in   pixel_column_i, pixel_row_i               in_valid_i & in_ready_o
// out      out  no_floor_o, cell_x/y_o, texel_x/y_o       out_valid_o & out_ready_i
// cfg      in   cfg_index_i, cfg_data_i                   cfg_valid_i & cfg_ready_o
//
// One pixel per cycle while no result is held at the output. The divider retires
// one quotient bit per register stage.
// Reset clears all valid bits and loads the default camera; cfg is always ready.
// A result held at the output stalls every stage at once; nothing is dropped.
// ----------------------------------------------------------------------------
module floor_cast_texel_address #(
  parameter int unsigned H_PIXELS = fcta_pkg::H_PIXELS_DEF,
  parameter int unsigned V_PIXELS = fcta_pkg::V_PIXELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fcta_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fcta_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [fcta_pkg::COL_W-1:0]           pixel_column_i,
  input  logic [fcta_pkg::ROW_W-1:0]           pixel_row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 no_floor_o,
  output logic signed [fcta_pkg::COORD_W-1:0]  cell_x_o,
  output logic signed [fcta_pkg::COORD_W-1:0]  cell_y_o,
  output logic [fcta_pkg::TEXEL_W-1:0]         texel_x_o,
  output logic [fcta_pkg::TEXEL_W-1:0]         texel_y_o
);

  localparam int unsigned COORD_W = fcta_pkg::COORD_W;
  localparam int unsigned TEXEL_W = fcta_pkg::TEXEL_W;
  localparam int unsigned LOG_W   = fcta_pkg::TEX_LOG_W;
  localparam int unsigned WORLD_W = fcta_pkg::WORLD_W;
  localparam int unsigned ROW_W   = fcta_pkg::ROW_W;

  localparam int unsigned HALF_H  = V_PIXELS / 2;
  localparam int unsigned WID_W   = $clog2(H_PIXELS + 1);
  localparam int unsigned H2_W    = $clog2(2 * V_PIXELS + 1);
  localparam int unsigned HH_W    = $clog2(HALF_H + 1);
  localparam int unsigned RD_W    = ((HH_W > ROW_W) ? HH_W : ROW_W) + 1;
  localparam int unsigned SPAN_W  = fcta_pkg::COL_W + 3;
  localparam int unsigned PRD_W   = COORD_W + SPAN_W;
  localparam int unsigned NUM_W   = PRD_W + 1;
  localparam int unsigned N_W     = NUM_W + H2_W;
  localparam int unsigned DEN_W   = ROW_W + WID_W;
  localparam int unsigned SKIP_W  = WID_W - 1;
  localparam int unsigned QW      = N_W - SKIP_W;
  localparam int unsigned QA_W    = QW + 1;
  localparam int unsigned EXT_W   = (QA_W > WORLD_W) ? QA_W : WORLD_W;
  localparam int unsigned LAT     = QW + 8;

  localparam logic signed [PRD_W-1:0] W_PRD = PRD_W'(H_PIXELS);
  localparam logic [DEN_W-1:0]        W_DEN = DEN_W'(H_PIXELS);
  localparam logic [N_W-1:0]          H2_N  = N_W'(2 * V_PIXELS);
  localparam logic [LOG_W-1:0]        TEX_MAX = LOG_W'(TEXEL_W);

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic nf;
  } side_t;

  // configuration
  logic [COORD_W-1:0]        pos_x_q, pos_y_q;
  logic signed [COORD_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [LOG_W-1:0]          tw_q, th_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= fcta_pkg::POS_X_RST;
      pos_y_q   <= fcta_pkg::POS_Y_RST;
      dir_x_q   <= fcta_pkg::DIR_X_RST;
      dir_y_q   <= fcta_pkg::DIR_Y_RST;
      plane_x_q <= fcta_pkg::PLANE_X_RST;
      plane_y_q <= fcta_pkg::PLANE_Y_RST;
      tw_q      <= fcta_pkg::TEX_W_LOG2_RST;
      th_q      <= fcta_pkg::TEX_H_LOG2_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fcta_pkg::CFG_POS_X:      pos_x_q   <= cfg_data_i;
        fcta_pkg::CFG_POS_Y:      pos_y_q   <= cfg_data_i;
        fcta_pkg::CFG_DIR_X:      dir_x_q   <= cfg_data_i;
        fcta_pkg::CFG_DIR_Y:      dir_y_q   <= cfg_data_i;
        fcta_pkg::CFG_PLANE_X:    plane_x_q <= cfg_data_i;
        fcta_pkg::CFG_PLANE_Y:    plane_y_q <= cfg_data_i;
        fcta_pkg::CFG_TEX_W_LOG2: tw_q      <= cfg_data_i[LOG_W-1:0];
        fcta_pkg::CFG_TEX_H_LOG2: th_q      <= cfg_data_i[LOG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 1: screen span and row offset
  logic signed [SPAN_W-1:0] span_d, s1_span_q;
  logic signed [RD_W-1:0]   rdiff_d;
  logic [ROW_W-1:0]         s1_p_q;
  logic                     s1_nf_q;

  always_comb begin
    span_d  = SPAN_W'({pixel_column_i, 1'b0}) - SPAN_W'(H_PIXELS);
    rdiff_d = RD_W'(pixel_row_i) - RD_W'(HALF_H);
  end

  // stage 2: products
  logic signed [PRD_W-1:0] mx_d, my_d, px_d, py_d;
  logic signed [PRD_W-1:0] s2_mx_q, s2_my_q, s2_px_q, s2_py_q;
  logic [DEN_W-1:0]        den_d, s2_den_q;
  logic                    s2_nf_q;

  always_comb begin
    mx_d  = PRD_W'(dir_x_q) * W_PRD;
    my_d  = PRD_W'(dir_y_q) * W_PRD;
    px_d  = PRD_W'(plane_x_q) * PRD_W'(s1_span_q);
    py_d  = PRD_W'(plane_y_q) * PRD_W'(s1_span_q);
    den_d = DEN_W'(s1_p_q) * W_DEN;
  end

  // stage 3: numerators
  logic signed [NUM_W-1:0] s3_numx_q, s3_numy_q;
  logic [DEN_W-1:0]        s3_den_q;
  logic                    s3_nf_q;

  // stage 4: magnitudes
  logic [NUM_W-1:0] magx_d, magy_d, s4_magx_q, s4_magy_q;
  logic [DEN_W-1:0] s4_den_q;
  logic             s4_negx_q, s4_negy_q, s4_nf_q;

  always_comb begin
    magx_d = s3_numx_q[NUM_W-1] ? (~s3_numx_q + NUM_W'(1)) : s3_numx_q;
    magy_d = s3_numy_q[NUM_W-1] ? (~s3_numy_q + NUM_W'(1)) : s3_numy_q;
  end

  // stage 5: scaled dividends
  logic [N_W-1:0]   s5_nx_q, s5_ny_q;
  logic [DEN_W-1:0] s5_den_q;
  side_t            s5_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_span_q <= span_d;
      s1_p_q    <= rdiff_d[ROW_W-1:0];
      s1_nf_q   <= rdiff_d[RD_W-1] || (rdiff_d == '0);

      s2_mx_q  <= mx_d;
      s2_my_q  <= my_d;
      s2_px_q  <= px_d;
      s2_py_q  <= py_d;
      s2_den_q <= den_d;
      s2_nf_q  <= s1_nf_q;

      s3_numx_q <= NUM_W'(s2_mx_q) + NUM_W'(s2_px_q);
      s3_numy_q <= NUM_W'(s2_my_q) + NUM_W'(s2_py_q);
      s3_den_q  <= s2_den_q;
      s3_nf_q   <= s2_nf_q;

      s4_magx_q <= magx_d;
      s4_magy_q <= magy_d;
      s4_negx_q <= s3_numx_q[NUM_W-1];
      s4_negy_q <= s3_numy_q[NUM_W-1];
      s4_den_q  <= s3_den_q;
      s4_nf_q   <= s3_nf_q;

      s5_nx_q   <= N_W'(s4_magx_q) * H2_N;
      s5_ny_q   <= N_W'(s4_magy_q) * H2_N;
      s5_den_q  <= s4_den_q;
      s5_side_q <= '{neg_x: s4_negx_q, neg_y: s4_negy_q, nf: s4_nf_q};
    end
  end

  // division stages
  logic [QW-1:0] quo_x, quo_y;
  logic          rnz_x, rnz_y;
  side_t         side_q [QW];

  fcta_divider #(
    .NUM_W (N_W),
    .DEN_W (DEN_W),
    .QUO_W (QW)
  ) u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (s5_nx_q),
    .den_i    (s5_den_q),
    .quo_o    (quo_x),
    .rem_nz_o (rnz_x)
  );

  fcta_divider #(
    .NUM_W (N_W),
    .DEN_W (DEN_W),
    .QUO_W (QW)
  ) u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (s5_ny_q),
    .den_i    (s5_den_q),
    .quo_o    (quo_y),
    .rem_nz_o (rnz_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s5_side_q;
      for (int k = 1; k < QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage 6: round toward minus infinity
  logic [QA_W-1:0] s6_qax_q, s6_qay_q;
  side_t           s6_side_q;

  // stage 7: world point
  logic [EXT_W-1:0]   basex_d, basey_d, wxe_d, wye_d;
  logic [WORLD_W-1:0] s7_wx_q, s7_wy_q;
  logic [LOG_W-1:0]   limx_d, limy_d, s7_limx_q, s7_limy_q;
  logic               s7_nf_q;

  always_comb begin
    basex_d = EXT_W'({pos_x_q, 8'h00});
    basey_d = EXT_W'({pos_y_q, 8'h00});
    wxe_d   = s6_side_q.neg_x ? (basex_d - EXT_W'(s6_qax_q)) : (basex_d + EXT_W'(s6_qax_q));
    wye_d   = s6_side_q.neg_y ? (basey_d - EXT_W'(s6_qay_q)) : (basey_d + EXT_W'(s6_qay_q));
    limx_d  = (tw_q > TEX_MAX) ? TEX_MAX : tw_q;
    limy_d  = (th_q > TEX_MAX) ? TEX_MAX : th_q;
  end

  // output stage
  logic [TEXEL_W-1:0] texx_d, texy_d;
  logic [LOG_W-1:0]   out_limx_q, out_limy_q;

  always_comb begin
    texx_d = s7_wx_q[COORD_W-1 -: TEXEL_W] >> (TEX_MAX - s7_limx_q);
    texy_d = s7_wy_q[COORD_W-1 -: TEXEL_W] >> (TEX_MAX - s7_limy_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_qax_q  <= QA_W'(quo_x) + QA_W'(side_q[QW-1].neg_x & rnz_x);
      s6_qay_q  <= QA_W'(quo_y) + QA_W'(side_q[QW-1].neg_y & rnz_y);
      s6_side_q <= side_q[QW-1];

      s7_wx_q   <= wxe_d[WORLD_W-1:0];
      s7_wy_q   <= wye_d[WORLD_W-1:0];
      s7_limx_q <= limx_d;
      s7_limy_q <= limy_d;
      s7_nf_q   <= s6_side_q.nf;

      no_floor_o <= s7_nf_q;
      cell_x_o   <= s7_nf_q ? '0 : s7_wx_q[WORLD_W-1 -: COORD_W];
      cell_y_o   <= s7_nf_q ? '0 : s7_wy_q[WORLD_W-1 -: COORD_W];
      texel_x_o  <= s7_nf_q ? '0 : texx_d;
      texel_y_o  <= s7_nf_q ? '0 : texy_d;
      out_limx_q <= s7_limx_q;
      out_limy_q <= s7_limy_q;
    end
  end

  a_no_floor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_floor_o |-> cell_x_o == '0 && cell_y_o == '0 &&
                                  texel_x_o == '0 && texel_y_o == '0)
    else $error("no_floor result carries nonzero fields");

  a_texel_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((16'(texel_x_o) >> out_limx_q) == 16'h0000))
    else $error("texel_x exceeds texture width");

  a_texel_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((16'(texel_y_o) >> out_limy_q) == 16'h0000))
    else $error("texel_y exceeds texture height");

endmodule

/* rtl/fcta_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor cast pipelined divider
// Unsigned restoring division, one quotient bit per register stage. The top
// numerator bits that form the first partial remainder must be below den_i.
// ----------------------------------------------------------------------------
module fcta_divider #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 19,
  parameter int unsigned QUO_W = 31
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             rem_nz_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] acc_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] acc_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign acc_in = num_i[QUO_W-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, acc_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        acc_q[k] <= {acc_in[QUO_W-2:0], ge};
      end
    end

    if (k < QUO_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o    = acc_q[QUO_W-1];
  assign rem_nz_o = |rem_q[QUO_W-1];

endmodule

/* bench/tb_floor_cast_texel_address.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Floor cast texel address testbench
// Sends screen pixels through the floor caster and compares each result
// (horizon flag, map cell, texel) against an exact rational predictor of the
// floor hit. The camera registers are loaded between phases once the pipe has
// drained. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_floor_cast_texel_address;

  localparam int unsigned COL_W     = fcta_pkg::COL_W;
  localparam int unsigned ROW_W     = fcta_pkg::ROW_W;
  localparam int unsigned COORD_W   = fcta_pkg::COORD_W;
  localparam int unsigned TEX_LOG_W = fcta_pkg::TEX_LOG_W;
  localparam int unsigned TEXEL_W   = fcta_pkg::TEXEL_W;
  localparam int unsigned WORLD_W   = fcta_pkg::WORLD_W;
  localparam int unsigned CFG_IDX_W = fcta_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DAT_W = fcta_pkg::CFG_DAT_W;

  localparam longint SCR_W        = longint'(fcta_pkg::H_PIXELS_DEF);
  localparam longint SCR_H        = longint'(fcta_pkg::V_PIXELS_DEF);
  localparam int     NUM_REGS     = fcta_pkg::CFG_TEX_H_LOG2 + 1;
  localparam int     TAIL_CYCLES  = 80;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     VIEW_PHASES  = 12;
  localparam int     PHASE_PIXELS = 152;
  localparam int     SHOW_LIMIT   = 10;

  typedef struct packed {
    logic                       no_floor;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [COORD_W-1:0]  cell_y;
    logic [TEXEL_W-1:0]         texel_x;
    logic [TEXEL_W-1:0]         texel_y;
  } floor_hit_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i    = '0;
  logic [CFG_DAT_W-1:0]     cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [COL_W-1:0]         pixel_column_i = '0;
  logic [ROW_W-1:0]         pixel_row_i    = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic                     no_floor_o;
  logic signed [COORD_W-1:0] cell_x_o;
  logic signed [COORD_W-1:0] cell_y_o;
  logic [TEXEL_W-1:0]       texel_x_o;
  logic [TEXEL_W-1:0]       texel_y_o;

  // camera copy used by the predictor
  logic [COORD_W-1:0]        cam_pos_x      = fcta_pkg::POS_X_RST;
  logic [COORD_W-1:0]        cam_pos_y      = fcta_pkg::POS_Y_RST;
  logic signed [COORD_W-1:0] cam_dir_x      = fcta_pkg::DIR_X_RST;
  logic signed [COORD_W-1:0] cam_dir_y      = fcta_pkg::DIR_Y_RST;
  logic signed [COORD_W-1:0] cam_plane_x    = fcta_pkg::PLANE_X_RST;
  logic signed [COORD_W-1:0] cam_plane_y    = fcta_pkg::PLANE_Y_RST;
  logic [TEX_LOG_W-1:0]      cam_tex_w_log2 = fcta_pkg::TEX_W_LOG2_RST;
  logic [TEX_LOG_W-1:0]      cam_tex_h_log2 = fcta_pkg::TEX_H_LOG2_RST;

  logic [CFG_DAT_W-1:0] view_regs [NUM_REGS];
  floor_hit_t           pending_hits [$];
  int                   err_count   = 0;
  int                   shown_count = 0;
  int                   cycle_count = 0;
  int unsigned          ready_wait  = 0;
  bit                   src_idle    = 1'b0;
  bit                   sink_idle   = 1'b0;

  floor_cast_texel_address u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .no_floor_o     (no_floor_o),
    .cell_x_o       (cell_x_o),
    .cell_y_o       (cell_y_o),
    .texel_x_o      (texel_x_o),
    .texel_y_o      (texel_y_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [WORLD_W-1:0] floor_world_q16(
    logic [COORD_W-1:0] pos, logic signed [COORD_W-1:0] dir,
    logic signed [COORD_W-1:0] plane, longint col, longint p);
    longint      num;
    longint      den;
    longint      off;
    logic [63:0] sum;
    num = (longint'(dir) * SCR_W + longint'(plane) * (2 * col - SCR_W)) * 2 * SCR_H;
    den = p * SCR_W;
    off = (num >= 0) ? num / den : -((-num + den - 1) / den);
    sum = (longint'(pos) << 8) + off;
    return sum[WORLD_W-1:0];
  endfunction

  function automatic logic [TEXEL_W-1:0] texel_bits(logic [15:0] frac,
                                                    logic [TEX_LOG_W-1:0] lg);
    int unsigned l;
    logic [15:0] top;
    l   = (lg > TEXEL_W) ? TEXEL_W : lg;
    top = frac >> (16 - l);
    return top[TEXEL_W-1:0];
  endfunction

  function automatic floor_hit_t predict_floor_hit(logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row);
    floor_hit_t         hit;
    longint             p;
    logic [WORLD_W-1:0] wx;
    logic [WORLD_W-1:0] wy;
    hit = '0;
    p   = longint'(row) - SCR_H / 2;
    if (p <= 0) begin
      hit.no_floor = 1'b1;
      return hit;
    end
    wx = floor_world_q16(cam_pos_x, cam_dir_x, cam_plane_x, longint'(col), p);
    wy = floor_world_q16(cam_pos_y, cam_dir_y, cam_plane_y, longint'(col), p);
    hit.cell_x  = wx[31:16];
    hit.cell_y  = wy[31:16];
    hit.texel_x = texel_bits(wx[15:0], cam_tex_w_log2);
    hit.texel_y = texel_bits(wy[15:0], cam_tex_h_log2);
    return hit;
  endfunction

  // hold valid across back-to-back transfers; drop it only for a gap
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    int unsigned gap;
    floor_hit_t  hit;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_column_i <= col;
    pixel_row_i    <= row;
    hit = predict_floor_hit(col, row);
    do @(posedge clk_i); while (!in_ready_o);
    pending_hits.push_back(hit);
  endtask

  task automatic send_random_pixel();
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) row = ROW_W'($urandom_range(SCR_H / 2 + 1, SCR_H - 1));
    else if (pick < 85) row = ROW_W'($urandom_range(SCR_H, (1 << ROW_W) - 1));
    else row = ROW_W'($urandom_range(0, SCR_H / 2));
    if ($urandom_range(0, 99) < 85) col = COL_W'($urandom_range(0, SCR_W - 1));
    else col = COL_W'($urandom_range(SCR_W, (1 << COL_W) - 1));
    send_pixel(col, row);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fcta_pkg::CFG_POS_X:      cam_pos_x      = data;
      fcta_pkg::CFG_POS_Y:      cam_pos_y      = data;
      fcta_pkg::CFG_DIR_X:      cam_dir_x      = data;
      fcta_pkg::CFG_DIR_Y:      cam_dir_y      = data;
      fcta_pkg::CFG_PLANE_X:    cam_plane_x    = data;
      fcta_pkg::CFG_PLANE_Y:    cam_plane_y    = data;
      fcta_pkg::CFG_TEX_W_LOG2: cam_tex_w_log2 = data[TEX_LOG_W-1:0];
      fcta_pkg::CFG_TEX_H_LOG2: cam_tex_h_log2 = data[TEX_LOG_W-1:0];
      default: ;
    endcase
  endtask

  // drain, then load all registers plus some writes to unmapped indexes
  task automatic load_view(input int spare_writes);
    logic [CFG_IDX_W-1:0] spare_idx;
    wait_idle();
    for (int i = fcta_pkg::CFG_POS_X; i <= fcta_pkg::CFG_TEX_H_LOG2; i++) begin
      write_reg(CFG_IDX_W'(i), view_regs[i]);
    end
    for (int i = 0; i < spare_writes; i++) begin
      spare_idx = CFG_IDX_W'(fcta_pkg::CFG_TEX_H_LOG2 + ((i % 8) + 1));
      write_reg(spare_idx, CFG_DAT_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return CFG_DAT_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_view();
    send_pixel(320, 0);
    send_pixel(320, 239);
    send_pixel(320, 240);
    send_pixel(320, 241);
    send_pixel(320, 479);
    send_pixel(320, 511);
    send_pixel(0, 241);
    send_pixel(639, 300);
    send_pixel(640, 400);
    send_pixel(1023, 511);
  endtask

  task automatic test_register_extremes();
    view_regs[fcta_pkg::CFG_POS_X]      = 16'hFFFF;
    view_regs[fcta_pkg::CFG_POS_Y]      = 16'h0000;
    view_regs[fcta_pkg::CFG_DIR_X]      = 16'h8000;
    view_regs[fcta_pkg::CFG_DIR_Y]      = 16'h7FFF;
    view_regs[fcta_pkg::CFG_PLANE_X]    = 16'h7FFF;
    view_regs[fcta_pkg::CFG_PLANE_Y]    = 16'h8000;
    view_regs[fcta_pkg::CFG_TEX_W_LOG2] = 16'd0;
    view_regs[fcta_pkg::CFG_TEX_H_LOG2] = 16'd15;
    load_view(0);
    send_pixel(0, 241);
    send_pixel(1023, 241);
    send_pixel(511, 511);
    send_pixel(320, 360);
    view_regs[fcta_pkg::CFG_POS_X]      = 16'h0000;
    view_regs[fcta_pkg::CFG_POS_Y]      = 16'hFFFF;
    view_regs[fcta_pkg::CFG_DIR_X]      = 16'h7FFF;
    view_regs[fcta_pkg::CFG_DIR_Y]      = 16'h8000;
    view_regs[fcta_pkg::CFG_PLANE_X]    = 16'h8000;
    view_regs[fcta_pkg::CFG_PLANE_Y]    = 16'h7FFF;
    view_regs[fcta_pkg::CFG_TEX_W_LOG2] = 16'd8;
    view_regs[fcta_pkg::CFG_TEX_H_LOG2] = 16'd1;
    load_view(0);
    send_pixel(0, 241);
    send_pixel(1023, 241);
    send_pixel(511, 511);
    send_pixel(320, 360);
  endtask

  task automatic test_ignored_index();
    view_regs[fcta_pkg::CFG_POS_X]      = 16'h0A80;
    view_regs[fcta_pkg::CFG_POS_Y]      = 16'h1240;
    view_regs[fcta_pkg::CFG_DIR_X]      = 16'hC000;
    view_regs[fcta_pkg::CFG_DIR_Y]      = 16'h2000;
    view_regs[fcta_pkg::CFG_PLANE_X]    = 16'h1A3D;
    view_regs[fcta_pkg::CFG_PLANE_Y]    = 16'hF000;
    view_regs[fcta_pkg::CFG_TEX_W_LOG2] = 16'd9;
    view_regs[fcta_pkg::CFG_TEX_H_LOG2] = 16'd5;
    load_view(8);
    send_pixel(100, 250);
    send_pixel(600, 400);
    send_pixel(320, 480);
  endtask

  task automatic test_random_views();
    for (int ph = 0; ph < VIEW_PHASES; ph++) begin
      for (int i = fcta_pkg::CFG_POS_X; i <= fcta_pkg::CFG_PLANE_Y; i++) begin
        view_regs[i] = pick_word();
      end
      view_regs[fcta_pkg::CFG_TEX_W_LOG2] = CFG_DAT_W'($urandom_range(0, 15));
      view_regs[fcta_pkg::CFG_TEX_H_LOG2] = CFG_DAT_W'($urandom_range(0, 15));
      load_view($urandom_range(0, 2));
      src_idle  = ph[0];
      sink_idle = ph[1];
      repeat (PHASE_PIXELS) send_random_pixel();
    end
  endtask

  always @(posedge clk_i) begin
    floor_hit_t got;
    floor_hit_t exp_hit;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{no_floor_o, cell_x_o, cell_y_o, texel_x_o, texel_y_o};
        if (pending_hits.size() == 0) begin
          err_count++;
          if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display("unexpected result: nf=%0b cell=(%0d,%0d) texel=(%0d,%0d)",
                     got.no_floor, got.cell_x, got.cell_y, got.texel_x, got.texel_y);
          end
        end else begin
          exp_hit = pending_hits.pop_front();
          if (got.no_floor !== exp_hit.no_floor || got.cell_x !== exp_hit.cell_x ||
              got.cell_y !== exp_hit.cell_y || got.texel_x !== exp_hit.texel_x ||
              got.texel_y !== exp_hit.texel_y) begin
            err_count++;
            if (shown_count < SHOW_LIMIT) begin
              shown_count++;
              $display("mismatch: exp nf=%0b cell=(%0d,%0d) texel=(%0d,%0d)",
                       exp_hit.no_floor, exp_hit.cell_x, exp_hit.cell_y,
                       exp_hit.texel_x, exp_hit.texel_y);
              $display("          got nf=%0b cell=(%0d,%0d) texel=(%0d,%0d)",
                       got.no_floor, got.cell_x, got.cell_y, got.texel_x, got.texel_y);
            end
          end
        end
        ready_wait = sink_idle ? $urandom_range(0, 3) : 0;
      end
      if (ready_wait != 0) begin
        out_ready_i <= 1'b0;
        ready_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_register_extremes();
    test_ignored_index();
    test_random_views();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    err_count += pending_hits.size();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
